### src/gesture_direction_classifier_core_macros.svh
// Assertion macros shared by the gesture classifier RTL.
`ifndef GESTURE_DIRECTION_CLASSIFIER_CORE_MACROS_SVH
`define GESTURE_DIRECTION_CLASSIFIER_CORE_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define GDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen on a clock edge outside reset.
`define GDC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `GDC_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

### src/gdc_pkg.sv
// Types, widths and constants of the gesture direction classifier.
package gdc_pkg;

  localparam int unsigned LevelW        = 8;
  localparam int unsigned DeltaW        = 15;
  localparam int unsigned MagW          = 15;
  localparam int unsigned CountW        = 7;
  localparam int unsigned ThrW          = 14;
  localparam int unsigned GainW         = 10;
  localparam int unsigned CodeW         = 3;
  localparam int unsigned TotalW        = MagW + 1;
  localparam int unsigned ProdW         = CountW + GainW;
  localparam int unsigned CfgAddrW      = 2;
  localparam int unsigned CfgDataW      = 14;
  localparam int unsigned InDataW       = 4 * LevelW;
  localparam int unsigned OutDataW      = 8;
  localparam int unsigned BurstDepthDef = 32;

  localparam logic [ThrW-1:0]  NoiseThrRst = ThrW'(10);
  localparam logic [ThrW-1:0]  AxisThrRst  = ThrW'(15);
  localparam logic [GainW-1:0] NearGainRst = GainW'(200);
  localparam logic [GainW-1:0] FarGainRst  = GainW'(20);

  typedef enum logic [CodeW-1:0] {
    GDC_NONE  = 3'd0,
    GDC_UP    = 3'd1,
    GDC_DOWN  = 3'd2,
    GDC_LEFT  = 3'd3,
    GDC_RIGHT = 3'd4,
    GDC_NEAR  = 3'd5,
    GDC_FAR   = 3'd6
  } gdc_code_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_NOISE_THR = 2'd0,
    REG_AXIS_THR  = 2'd1,
    REG_NEAR_GAIN = 2'd2,
    REG_FAR_GAIN  = 2'd3
  } gdc_reg_e;

  typedef struct packed {
    logic [ThrW-1:0]  noise_thr;
    logic [ThrW-1:0]  axis_thr;
    logic [GainW-1:0] near_gain;
    logic [GainW-1:0] far_gain;
  } gdc_cfg_t;

  // Accumulated burst, handed from the accumulator to the classifier.
  typedef struct packed {
    logic signed [DeltaW-1:0] vdelta;
    logic signed [DeltaW-1:0] hdelta;
    logic [MagW-1:0]          vmag;
    logic [MagW-1:0]          hmag;
    logic [CountW-1:0]        count;
    logic                     ovf;
  } gdc_burst_t;

endpackage

### src/gdc_accum.sv
// Burst accumulator: running sums per dataset beat, snapshot register at burst end.
module gdc_accum #(
  parameter int unsigned BURST_DEPTH = gdc_pkg::BurstDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gdc_pkg::LevelW-1:0]        up_i,
  input  logic [gdc_pkg::LevelW-1:0]        down_i,
  input  logic [gdc_pkg::LevelW-1:0]        left_i,
  input  logic [gdc_pkg::LevelW-1:0]        right_i,
  input  logic                              last_i,
  output logic                              snap_valid_o,
  input  logic                              snap_ready_i,
  output gdc_pkg::gdc_burst_t               snap_o
);
  import gdc_pkg::*;

  gdc_burst_t acc_q, acc_d, acc_next;
  gdc_burst_t snap_q;
  logic       snap_valid_q, snap_valid_d;
  logic       in_fire, room;

  logic signed [LevelW:0] vdiff, hdiff;
  logic [LevelW:0]        vsum, hsum;

  assign in_ready_o = !snap_valid_q || snap_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign room       = acc_q.count < CountW'(BURST_DEPTH);

  always_comb begin
    vdiff = $signed({1'b0, up_i}) - $signed({1'b0, down_i});
    hdiff = $signed({1'b0, left_i}) - $signed({1'b0, right_i});
    vsum  = {1'b0, up_i} + {1'b0, down_i};
    hsum  = {1'b0, left_i} + {1'b0, right_i};

    acc_next = acc_q;
    if (room) begin
      acc_next.vdelta = acc_q.vdelta + {{(DeltaW-LevelW-1){vdiff[LevelW]}}, vdiff};
      acc_next.hdelta = acc_q.hdelta + {{(DeltaW-LevelW-1){hdiff[LevelW]}}, hdiff};
      acc_next.vmag   = acc_q.vmag + {{(MagW-LevelW-1){1'b0}}, vsum};
      acc_next.hmag   = acc_q.hmag + {{(MagW-LevelW-1){1'b0}}, hsum};
      acc_next.count  = acc_q.count + CountW'(1);
    end else begin
      acc_next.ovf = 1'b1;
    end

    acc_d = acc_q;
    if (in_fire) begin
      acc_d = last_i ? '0 : acc_next;
    end

    snap_valid_d = (snap_valid_q && !snap_ready_i) || (in_fire && last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_i) begin
      snap_q <= acc_next;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

### src/gdc_classify.sv
// Burst classifier: thresholds, near/far test and axis pick into the result register.
module gdc_classify (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   snap_valid_i,
  output logic                   snap_ready_o,
  input  gdc_pkg::gdc_burst_t    snap_i,
  input  gdc_pkg::gdc_cfg_t      cfg_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output gdc_pkg::gdc_code_e     code_o,
  output logic                   too_long_o
);
  import gdc_pkg::*;

  logic [DeltaW-1:0] va, ha;
  logic [DeltaW-1:0] noise_ext, axis_ext;
  logic [TotalW-1:0] total;
  logic [ProdW-1:0]  near_prod, far_prod, total_ext;
  logic              v_pos, h_pos, load;
  gdc_code_e         code_d, code_q;
  logic              too_long_q;
  logic              out_valid_q, out_valid_d;

  assign snap_ready_o = !out_valid_q || out_ready_i;
  assign load         = snap_valid_i && snap_ready_o;

  always_comb begin
    va        = snap_i.vdelta[DeltaW-1] ? (~snap_i.vdelta + 1'b1) : snap_i.vdelta;
    ha        = snap_i.hdelta[DeltaW-1] ? (~snap_i.hdelta + 1'b1) : snap_i.hdelta;
    noise_ext = {{(DeltaW-ThrW){1'b0}}, cfg_i.noise_thr};
    axis_ext  = {{(DeltaW-ThrW){1'b0}}, cfg_i.axis_thr};
    total     = {1'b0, snap_i.vmag} + {1'b0, snap_i.hmag};
    total_ext = {{(ProdW-TotalW){1'b0}}, total};
    near_prod = {{(ProdW-CountW){1'b0}}, snap_i.count}
              * {{(ProdW-GainW){1'b0}}, cfg_i.near_gain};
    far_prod  = {{(ProdW-CountW){1'b0}}, snap_i.count}
              * {{(ProdW-GainW){1'b0}}, cfg_i.far_gain};
    v_pos     = !snap_i.vdelta[DeltaW-1] && (|snap_i.vdelta);
    h_pos     = !snap_i.hdelta[DeltaW-1] && (|snap_i.hdelta);

    if (snap_i.ovf) begin
      code_d = GDC_NONE;
    end else if (va < noise_ext && ha < noise_ext) begin
      code_d = GDC_NONE;
    end else if (va < axis_ext && ha < axis_ext) begin
      if (total_ext > near_prod) begin
        code_d = GDC_NEAR;
      end else if (total_ext < far_prod) begin
        code_d = GDC_FAR;
      end else begin
        code_d = GDC_NONE;
      end
    end else if (va > ha) begin
      code_d = v_pos ? GDC_UP : GDC_DOWN;
    end else begin
      // equal axes fall to horizontal; zero delta there reads as right
      code_d = h_pos ? GDC_LEFT : GDC_RIGHT;
    end

    out_valid_d = load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q     <= code_d;
      too_long_q <= snap_i.ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = code_q;
  assign too_long_o  = too_long_q;

endmodule

### src/gesture_direction_classifier_core.sv
// Gesture direction classifier: top level with config registers and stream ports.
//
// Usage: each input beat on s_axis carries one gesture dataset (four photodiode
// bytes) and tlast marks the final dataset of a burst. Non-final beats produce no
// output; the final beat produces one result beat on m_axis with the gesture
// code in tdata and the burst-too-long flag in tuser.
// Throughput: one dataset beat per clock unless m_axis stalls; bursts may follow
// back to back. The tlast beat fills the burst snapshot register, which then
// loads the result register that drives m_axis tvalid.
// The accumulator keeps at most BURST_DEPTH datasets; further beats of the same
// burst are dropped and the burst reports code none with tuser set.
// Reset clears the running sums, empties both pipeline registers and loads the
// threshold and gain registers with their defaults.
// When m_axis stalls, the result register holds and the next burst snapshot
// waits; s_axis tready then drops for every beat until the snapshot can move on.
// Config writes (cfg_we_i) take effect on the next clock and belong while idle.
module gesture_direction_classifier_core #(
  parameter int unsigned BURST_DEPTH = gdc_pkg::BurstDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // up [7:0], down [15:8], left [23:16], right [31:24]
  input  logic [gdc_pkg::InDataW-1:0]     s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // gesture_code [2:0], zero [7:3]
  output logic [gdc_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // burst_too_long [0]
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic                            cfg_we_i,
  input  logic [gdc_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [gdc_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import gdc_pkg::*;

`include "gesture_direction_classifier_core_macros.svh"

  gdc_cfg_t   cfg_q, cfg_d;
  gdc_burst_t snap;
  logic       snap_valid, snap_ready;
  gdc_code_e  code;
  logic       too_long;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (gdc_reg_e'(cfg_addr_i))
        REG_NOISE_THR: cfg_d.noise_thr = cfg_wdata_i[ThrW-1:0];
        REG_AXIS_THR:  cfg_d.axis_thr  = cfg_wdata_i[ThrW-1:0];
        REG_NEAR_GAIN: cfg_d.near_gain = cfg_wdata_i[GainW-1:0];
        REG_FAR_GAIN:  cfg_d.far_gain  = cfg_wdata_i[GainW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_thr <= NoiseThrRst;
      cfg_q.axis_thr  <= AxisThrRst;
      cfg_q.near_gain <= NearGainRst;
      cfg_q.far_gain  <= FarGainRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gdc_accum #(
    .BURST_DEPTH (BURST_DEPTH)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .up_i         (s_axis_tdata_i[LevelW-1:0]),
    .down_i       (s_axis_tdata_i[2*LevelW-1:LevelW]),
    .left_i       (s_axis_tdata_i[3*LevelW-1:2*LevelW]),
    .right_i      (s_axis_tdata_i[4*LevelW-1:3*LevelW]),
    .last_i       (s_axis_tlast_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  gdc_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .cfg_i        (cfg_q),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .code_o       (code),
    .too_long_o   (too_long)
  );

  assign m_axis_tdata_o = {{(OutDataW-CodeW){1'b0}}, code};
  assign m_axis_tuser_o = too_long;

  `GDC_ASSERT(a_last_makes_snap, clk_i, rst_ni,
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> snap_valid,
    "tlast beat did not produce a burst snapshot")

  `GDC_ASSERT(a_snap_count, clk_i, rst_ni,
    snap_valid && !snap.ovf |-> (snap.count != '0) && (snap.count <= CountW'(BURST_DEPTH)),
    "burst snapshot count out of range")

  `GDC_ASSERT(a_snap_hold, clk_i, rst_ni,
    snap_valid && !snap_ready |=> snap_valid && $stable(snap),
    "stalled burst snapshot changed")

  `GDC_ASSERT_NEVER(a_ovf_code, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o && (code != GDC_NONE),
    "overlong burst reported a gesture")

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for gesture_direction_classifier_core: bursts in, gesture codes checked.
module tb;
  import gdc_pkg::*;

  localparam int unsigned Depth         = 32;
  localparam int unsigned IdleLimit     = 3000;
  localparam int unsigned SqueezeCycles = 400;
  localparam int unsigned PhaseItems    = 120;
  localparam int unsigned NumPhases     = 8;

  typedef struct {
    gdc_code_e code;
    logic      too_long;
  } gesture_t;

  // Tracks the running burst sums and the gestures still owed by the block.
  class gesture_tracker #(int unsigned BurstMax = 32);
    gdc_cfg_t   regs;
    gdc_burst_t acc;
    gesture_t   pending_gestures[$];
    int         mismatches;
    int         gestures_seen;
    int         datasets_in;
    int         too_long_seen;
    int         code_hist[8];

    function new();
      regs.noise_thr = NoiseThrRst;
      regs.axis_thr  = AxisThrRst;
      regs.near_gain = NearGainRst;
      regs.far_gain  = FarGainRst;
      acc = '0;
    endfunction

    function void set_register(gdc_reg_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_NOISE_THR: regs.noise_thr = val;
        REG_AXIS_THR:  regs.axis_thr  = val;
        REG_NEAR_GAIN: regs.near_gain = val[GainW-1:0];
        REG_FAR_GAIN:  regs.far_gain  = val[GainW-1:0];
        default: ;
      endcase
    endfunction

    function gdc_code_e classify_burst();
      int vd, hd, va, ha, total;
      vd = int'($signed(acc.vdelta));
      hd = int'($signed(acc.hdelta));
      va = (vd < 0) ? -vd : vd;
      ha = (hd < 0) ? -hd : hd;
      if (va < int'(regs.noise_thr) && ha < int'(regs.noise_thr)) return GDC_NONE;
      if (va < int'(regs.axis_thr) && ha < int'(regs.axis_thr)) begin
        total = int'(acc.vmag) + int'(acc.hmag);
        if (total > int'(acc.count) * int'(regs.near_gain)) return GDC_NEAR;
        if (total < int'(acc.count) * int'(regs.far_gain)) return GDC_FAR;
        return GDC_NONE;
      end
      // ties fall to the horizontal axis
      if (va > ha) return (vd > 0) ? GDC_UP : GDC_DOWN;
      return (hd > 0) ? GDC_LEFT : GDC_RIGHT;
    endfunction

    function void absorb_dataset(logic [7:0] up, logic [7:0] dn, logic [7:0] lf,
                                 logic [7:0] rt, logic last);
      gesture_t g;
      datasets_in++;
      if (acc.count < BurstMax) begin
        acc.vdelta = DeltaW'(int'($signed(acc.vdelta)) + int'(up) - int'(dn));
        acc.hdelta = DeltaW'(int'($signed(acc.hdelta)) + int'(lf) - int'(rt));
        acc.vmag   = MagW'(int'(acc.vmag) + int'(up) + int'(dn));
        acc.hmag   = MagW'(int'(acc.hmag) + int'(lf) + int'(rt));
        acc.count  = acc.count + 1'b1;
      end else begin
        acc.ovf = 1'b1;
      end
      if (!last) return;
      if (acc.ovf) begin
        g.code     = GDC_NONE;
        g.too_long = 1'b1;
      end else begin
        g.code     = classify_burst();
        g.too_long = 1'b0;
      end
      pending_gestures.push_back(g);
      acc = '0;
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic flag);
      gesture_t want;
      gestures_seen++;
      code_hist[data[CodeW-1:0]]++;
      if (flag) too_long_seen++;
      if (pending_gestures.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected gesture beat: tdata 0x%02h tuser %b", data, flag);
        return;
      end
      want = pending_gestures.pop_front();
      if (data !== {{(OutDataW-CodeW){1'b0}}, want.code} || flag !== want.too_long) begin
        mismatches++;
        if (mismatches <= 10)
          $display("gesture %0d mismatch: expected code %0d too_long %b, got tdata 0x%02h tuser %b",
                   gestures_seen, want.code, want.too_long, data, flag);
      end
    endfunction
  endclass

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic [InDataW-1:0]  in_data   = '0;
  logic                in_last   = 1'b0;
  logic                in_valid  = 1'b0;
  logic                out_ready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  logic                s_axis_tready_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tvalid_o;

  gesture_tracker #(Depth) tracker;

  bit tx_calm      = 1'b0;
  bit rx_calm      = 1'b0;
  bit short_bursts = 1'b0;
  bit squeeze_req  = 1'b0;
  int stall_left   = 0;
  int idle_cycles  = 0;
  int settings_used = 1;

  gesture_direction_classifier_core #(
    .BURST_DEPTH(Depth)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (in_data),
    .s_axis_tlast_i (in_last),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(out_ready),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [7:0] near_level(logic [7:0] base);
    int v;
    v = int'(base) + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall_left  = SqueezeCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_calm && $urandom_range(99) < 25) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && out_ready)
      tracker.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && s_axis_tready_o) || (m_axis_tvalid_o && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("stream stuck for %0d cycles, %0d gestures outstanding",
                   idle_cycles, tracker.pending_gestures.size());
          $display("[gesture_direction_classifier_core] ERROR");
          $finish;
        end
      end
    end
  end

  // Called and returns at a falling edge.
  task automatic push_dataset(input logic [7:0] up, input logic [7:0] dn,
                              input logic [7:0] lf, input logic [7:0] rt, input logic last);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {rt, lf, dn, up};
    in_last  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tracker.absorb_dataset(up, dn, lf, rt, last);
    @(negedge clk_i);
  endtask

  task automatic random_burst(output int len);
    int pick, style, side;
    logic [7:0] lv[4];
    pick = $urandom_range(99);
    if (short_bursts) len = $urandom_range(2, 1);
    else if (pick < 70) len = $urandom_range(6, 1);
    else if (pick < 90) len = $urandom_range(20, 7);
    else len = $urandom_range(40, 31);
    style = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: for (int k = 0; k < 4; k++) lv[k] = 8'($urandom_range(255));
        1: begin
          // balanced pairs: small deltas, so the noise and near/far paths get hit
          lv[0] = 8'($urandom_range(255));
          lv[1] = near_level(lv[0]);
          lv[2] = 8'($urandom_range(255));
          lv[3] = near_level(lv[2]);
        end
        2: begin
          side = $urandom_range(3);
          for (int k = 0; k < 4; k++)
            lv[k] = (k == side) ? 8'($urandom_range(255, 150)) : 8'($urandom_range(60));
        end
        default: for (int k = 0; k < 4; k++) lv[k] = 8'($urandom_range(8));
      endcase
      push_dataset(lv[0], lv[1], lv[2], lv[3], i == len - 1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_gestures.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input gdc_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
    tracker.set_register(idx, val);
  endtask

  // Gains get random junk above bit 9; the block must ignore it.
  task automatic apply_settings(input int noise, input int axis, input int near_g,
                                input int far_g);
    logic [3:0] hi_near, hi_far;
    hi_near = 4'($urandom_range(15));
    hi_far  = 4'($urandom_range(15));
    write_reg(REG_NOISE_THR, CfgDataW'(noise));
    write_reg(REG_AXIS_THR, CfgDataW'(axis));
    write_reg(REG_NEAR_GAIN, {hi_near, GainW'(near_g)});
    write_reg(REG_FAR_GAIN, {hi_far, GainW'(far_g)});
    settings_used++;
  endtask

  initial begin
    int sent, len, noise;
    tracker = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset thresholds: noise 10, axis 15, near 200, far 20
    push_dataset(8'd255, 8'd0, 8'd0, 8'd0, 1'b1);       // up
    push_dataset(8'd0, 8'd255, 8'd0, 8'd0, 1'b1);       // down
    push_dataset(8'd0, 8'd0, 8'd255, 8'd0, 1'b1);       // left
    push_dataset(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);       // right
    push_dataset(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);         // noise
    push_dataset(8'd255, 8'd255, 8'd255, 8'd255, 1'b1); // noise, full scale
    push_dataset(8'd140, 8'd128, 8'd100, 8'd100, 1'b1); // near
    push_dataset(8'd12, 8'd0, 8'd0, 8'd0, 1'b1);        // far
    push_dataset(8'd40, 8'd28, 8'd0, 8'd0, 1'b1);       // between near and far
    push_dataset(8'd100, 8'd0, 8'd100, 8'd0, 1'b1);     // tie, goes left
    push_dataset(8'd0, 8'd100, 8'd0, 8'd100, 1'b1);     // tie, goes right
    push_dataset(8'd10, 8'd0, 8'd0, 8'd0, 1'b0);
    push_dataset(8'd10, 8'd0, 8'd0, 8'd0, 1'b0);
    push_dataset(8'd10, 8'd0, 8'd0, 8'd0, 1'b1);        // up over three datasets
    push_dataset(8'd0, 8'd0, 8'd0, 8'd200, 1'b0);
    push_dataset(8'd50, 8'd0, 8'd0, 8'd0, 1'b1);        // right beats up
    push_dataset(8'd6, 8'd0, 8'd0, 8'd0, 1'b0);
    push_dataset(8'd6, 8'd0, 8'd0, 8'd0, 1'b1);         // far over two datasets
    push_dataset(8'd200, 8'd0, 8'd0, 8'd50, 1'b0);
    push_dataset(8'd0, 8'd200, 8'd60, 8'd0, 1'b0);
    push_dataset(8'd0, 8'd5, 8'd0, 8'd0, 1'b1);         // mixed signs

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      tx_calm      = (phase == 2) || (phase == 6);
      rx_calm      = (phase == 3) || (phase == 6);
      short_bursts = (phase == 5);
      case (phase)
        0: ;
        1: begin
          apply_settings(0, 0, 0, 0);
          push_dataset(8'd128, 8'd128, 8'd128, 8'd128, 1'b1); // zero tie, goes right
        end
        2: apply_settings(16383, 16383, 1023, 1023);
        3: apply_settings(0, 16383, $urandom_range(700, 200), $urandom_range(150));
        5: begin
          apply_settings(10, 15, 200, 20);
          squeeze_req = 1'b1;
        end
        default: begin
          noise = $urandom_range(120);
          apply_settings(noise, noise + $urandom_range(400), $urandom_range(900, 100),
                         $urandom_range(200));
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        random_burst(len);
        sent += len;
      end
    end

    settle();
    repeat (4) @(negedge clk_i);
    $display("%0d datasets over %0d threshold settings; %0d gestures checked, %0d too long",
             tracker.datasets_in, settings_used, tracker.gestures_seen, tracker.too_long_seen);
    $display("codes none/up/down/left/right/near/far: %0d %0d %0d %0d %0d %0d %0d",
             tracker.code_hist[0], tracker.code_hist[1], tracker.code_hist[2],
             tracker.code_hist[3], tracker.code_hist[4], tracker.code_hist[5],
             tracker.code_hist[6]);
    if (tracker.mismatches == 0 && tracker.pending_gestures.size() == 0) begin
      $display("[gesture_direction_classifier_core] OK");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("[gesture_direction_classifier_core] ERROR");
    end
    $finish;
  end

endmodule
